// ----- hw/rtl/aip_pkg.sv -----
// Shared types and constants for the ASCII integer parser.
// Used by the character decoder, the parse core, the top level and the checker.
package aip_pkg;

   // Field widths of the stream words.
   localparam int CH_W        = 8;
   localparam int VALUE_W     = 64;
   localparam int COUNT_W     = 12;
   localparam int BASE_W      = 6;
   localparam int DIGIT_W     = 7;
   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 80;
   localparam int RSP_TUSER_W = 2;
   localparam int RSP_PAD_W   = RSP_TDATA_W - VALUE_W - COUNT_W;

   // Arithmetic width of the parsed number and the saturation point of the count.
   localparam int VALUE_BITS = 64;
   localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(4095);

   // Configuration port.
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 6;
   localparam logic [CSR_ADDR_W-1:0] REG_NUMBER_BASE = CSR_ADDR_W'(0);
   localparam logic [CSR_ADDR_W-1:0] REG_SIGNED_MODE = CSR_ADDR_W'(1);
   localparam logic [BASE_W-1:0]     NUMBER_BASE_RST = BASE_W'(10);

   // Radix values used while resolving the base.
   localparam logic [BASE_W-1:0] BASE_AUTO = BASE_W'(0);
   localparam logic [BASE_W-1:0] BASE_OCT  = BASE_W'(8);
   localparam logic [BASE_W-1:0] BASE_DEC  = BASE_W'(10);
   localparam logic [BASE_W-1:0] BASE_HEX  = BASE_W'(16);

   // Digit value of a byte that is no letter or number.
   localparam logic [DIGIT_W-1:0] NOT_DIGIT = DIGIT_W'(64);

   // Bit positions of the result flags in rsp_tuser.
   localparam int FLAG_RANGE    = 0;
   localparam int FLAG_NODIGITS = 1;

   // Decoded class of one text byte.
   typedef struct packed {
      logic               is_space;
      logic               is_sign;
      logic               is_minus;
      logic               is_zero;
      logic               is_x;
      logic [DIGIT_W-1:0] digit;
   } char_class_type;

endpackage

// ----- hw/rtl/ascii_integer_parser.sv -----
// Top level of the ASCII integer parser: input stage, configuration registers,
// character decoder and parse core. Depends on aip_pkg, aip_char_decode, aip_parse.
//
// Usage:
//   The req channel carries one byte of text per word in req_tdata; req_tuser is
//   high on the first byte of a new string and drops any number still in progress.
//   Leading whitespace and one sign are skipped, the radix is taken from
//   number_base (0 detects octal, decimal or hex), and digits are accumulated.
//   The byte that ends the number (a NUL always does) yields one word on the rsp
//   channel: the value and the consumed count in rsp_tdata, the range_error and
//   no_digits flags in rsp_tuser. Bytes outside a string give no word.
//   The csr port writes number_base (index 0) and signed_mode (index 1); write it
//   only while no string is being parsed.
// Timing:
//   One byte per cycle sustained unless a result waits on rsp_tready. A byte
//   accepted into the input stage steps through the parse logic from there, and
//   its result word is registered in the result register until it is taken. The
//   per-byte loop is one 64 by 6 bit multiply-add with a limit compare on the
//   parse state.
// Reset and stall:
//   Reset empties the input stage and the result register, returns the parser to
//   idle and sets number_base to 10 and signed_mode to 1. While a result waits on
//   rsp_tready, one more byte is held in the input stage; then req_tready drops.
module ascii_integer_parser
   import aip_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // Text input.
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // ch
   input  logic                   req_tuser,  // first
   // Parsed results.
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,  // value[63:0], consumed[75:64], zero pad
   output logic [RSP_TUSER_W-1:0] rsp_tuser,  // range_error, no_digits
   // Configuration writes.
   input  logic                   csr_we,
   input  logic [CSR_ADDR_W-1:0]  csr_addr,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic                 stage_valid_ff, stage_valid_in;
   char_class_type       stage_char_ff;
   logic                 stage_first_ff;
   char_class_type       req_char;
   logic                 step_ready;
   logic [BASE_W-1:0]    number_base_ff;
   logic                 signed_mode_ff;

   // Classify the incoming byte before it is registered.
   aip_char_decode u_decode (
      .ch  (req_tdata[CH_W-1:0]),
      .cls (req_char)
   );

   // Input stage: takes a byte whenever it is empty or stepping this cycle.
   assign req_tready     = !stage_valid_ff || step_ready;
   assign stage_valid_in = req_tready ? req_tvalid : stage_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         stage_char_ff  <= req_char;
         stage_first_ff <= req_tuser;
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         number_base_ff <= NUMBER_BASE_RST;
         signed_mode_ff <= 1'b1;
      end else if (csr_we) begin
         case (csr_addr)
            REG_NUMBER_BASE: number_base_ff <= csr_wdata[BASE_W-1:0];
            REG_SIGNED_MODE: signed_mode_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   aip_parse u_parse (
      .clock       (clock),
      .reset       (reset),
      .step_valid  (stage_valid_ff),
      .step_ready  (step_ready),
      .step_char   (stage_char_ff),
      .step_first  (stage_first_ff),
      .number_base (number_base_ff),
      .signed_mode (signed_mode_ff),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

endmodule

// ----- hw/rtl/aip_char_decode.sv -----
// Character classifier of the ASCII integer parser.
// Depends on aip_pkg for the class struct and the digit constants.
module aip_char_decode
   import aip_pkg::*;
(
   input  logic [CH_W-1:0] ch,
   output char_class_type  cls
);

   // Whitespace, sign, prefix characters and the digit value of letters and numbers.
   always_comb begin
      cls.is_space = (ch == 8'h20) || (ch == 8'h09) || (ch == 8'h0A) ||
                     (ch == 8'h0D) || (ch == 8'h0C) || (ch == 8'h0B);
      cls.is_sign  = (ch == 8'h2B) || (ch == 8'h2D);
      cls.is_minus = (ch == 8'h2D);
      cls.is_zero  = (ch == 8'h30);
      cls.is_x     = (ch == 8'h78) || (ch == 8'h58);
      if (ch >= 8'h30 && ch <= 8'h39) begin
         cls.digit = DIGIT_W'(ch - 8'h30);
      end else if (ch >= 8'h61 && ch <= 8'h7A) begin
         cls.digit = DIGIT_W'(ch - 8'h57);
      end else if (ch >= 8'h41 && ch <= 8'h5A) begin
         cls.digit = DIGIT_W'(ch - 8'h37);
      end else begin
         cls.digit = NOT_DIGIT;
      end
   end

endmodule

// ----- hw/rtl/aip_parse.sv -----
// Parse core of the ASCII integer parser: parse state, digit multiply-add
// with overflow check, and the result register. Depends on aip_pkg.
module aip_parse
   import aip_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // Decoded character from the input stage.
   input  logic                   step_valid,
   output logic                   step_ready,
   input  char_class_type         step_char,
   input  logic                   step_first,
   // Configuration.
   input  logic [BASE_W-1:0]      number_base,
   input  logic                   signed_mode,
   // Result channel.
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,  // value, consumed, zero pad
   output logic [RSP_TUSER_W-1:0] rsp_tuser   // range_error, no_digits
);

   localparam int SUM_W = VALUE_BITS + BASE_W + 1;

   localparam logic [2:0] PH_IDLE   = 3'd0;
   localparam logic [2:0] PH_SPACE  = 3'd1;
   localparam logic [2:0] PH_SIGNED = 3'd2;
   localparam logic [2:0] PH_ZERO   = 3'd3;
   localparam logic [2:0] PH_XMARK  = 3'd4;
   localparam logic [2:0] PH_DIGITS = 3'd5;

   // Parse state.
   logic [2:0]            phase_ff, phase_in;
   logic                  negative_ff, negative_in;
   logic [BASE_W-1:0]     base_ff, base_in;
   logic [VALUE_BITS-1:0] acc_ff, acc_in;
   logic                  ovf_ff, ovf_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic                  seen_ff, seen_in;

   // Result register.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]    rsp_value_ff, rsp_value_in;
   logic                  rsp_range_ff, rsp_range_in;
   logic                  rsp_none_ff, rsp_none_in;
   logic [COUNT_W-1:0]    rsp_count_ff, rsp_count_in;

   logic                  emit;
   logic                  advance;

   // Saturating character count.
   function automatic logic [COUNT_W-1:0] count_add(input logic [COUNT_W-1:0] cnt,
                                                    input logic [1:0] n);
      logic [COUNT_W:0] t;
      t = {1'b0, cnt} + (COUNT_W + 1)'(n);
      return (t > (COUNT_W + 1)'(MAX_COUNT)) ? MAX_COUNT : t[COUNT_W-1:0];
   endfunction

   // One digit step: acc * base + digit, flagged when it passes the limit.
   function automatic logic [VALUE_BITS:0] mac(input logic [VALUE_BITS-1:0] acc,
                                               input logic [BASE_W-1:0] base,
                                               input logic [DIGIT_W-1:0] d,
                                               input logic [VALUE_BITS-1:0] lim);
      logic [SUM_W-1:0]  sum;
      logic [BASE_W-1:0] b;
      b   = (base == BASE_AUTO) ? BASE_DEC : base;
      sum = SUM_W'(acc) * SUM_W'(b) + SUM_W'(d);
      return {sum > SUM_W'(lim), sum[VALUE_BITS-1:0]};
   endfunction

   assign step_ready = !rsp_valid_ff || rsp_tready;
   assign advance    = step_valid && step_ready;

   // Next parse state and result for the character in the input stage.
   always_comb begin
      logic                  done;
      logic [VALUE_BITS-1:0] lim;
      logic [VALUE_BITS-1:0] half;
      logic [VALUE_BITS-1:0] v;
      logic [VALUE_BITS:0]   m;

      phase_in    = phase_ff;
      negative_in = negative_ff;
      base_in     = base_ff;
      acc_in      = acc_ff;
      ovf_in      = ovf_ff;
      count_in    = count_ff;
      seen_in     = seen_ff;
      emit        = 1'b0;
      done        = 1'b0;
      v           = '0;
      m           = '0;
      rsp_value_in = '0;
      rsp_range_in = 1'b0;
      rsp_none_in  = 1'b0;
      rsp_count_in = '0;

      // A first character abandons whatever was in progress.
      if (step_first) begin
         phase_in    = PH_SPACE;
         negative_in = 1'b0;
         base_in     = '0;
         acc_in      = '0;
         ovf_in      = 1'b0;
         count_in    = '0;
         seen_in     = 1'b0;
      end

      // Largest magnitude that the sign and mode allow; also the saturation value.
      half = {1'b0, {(VALUE_BITS - 1){1'b1}}};
      if (!signed_mode) begin
         lim = '1;
      end else if (negative_in) begin
         lim = half + VALUE_BITS'(1);
      end else begin
         lim = half;
      end

      // Leading whitespace, then an optional sign.
      if (phase_in == PH_SPACE) begin
         if (step_char.is_space) begin
            count_in = count_add(count_in, 2'd1);
            done     = 1'b1;
         end else begin
            phase_in = PH_SIGNED;
            if (step_char.is_sign) begin
               negative_in = step_char.is_minus;
               count_in    = count_add(count_in, 2'd1);
               done        = 1'b1;
            end
         end
      end

      // Resolve the radix; a leading zero may start a prefix.
      if (!done && phase_in == PH_SIGNED) begin
         if ((number_base == BASE_AUTO || number_base == BASE_HEX) && step_char.is_zero) begin
            base_in  = number_base;
            acc_in   = '0;
            seen_in  = 1'b1;
            count_in = count_add(count_in, 2'd1);
            phase_in = PH_ZERO;
            done     = 1'b1;
         end else begin
            base_in  = (number_base == BASE_AUTO) ? BASE_DEC : number_base;
            phase_in = PH_DIGITS;
         end
      end

      // After a leading zero: an x marks hex, otherwise octal or plain hex digits.
      if (!done && phase_in == PH_ZERO) begin
         if (step_char.is_x) begin
            phase_in = PH_XMARK;
            done     = 1'b1;
         end else begin
            base_in  = (base_in == BASE_AUTO) ? BASE_OCT : BASE_HEX;
            phase_in = PH_DIGITS;
         end
      end

      // After the x the prefix counts only if a hex digit follows.
      if (!done && phase_in == PH_XMARK) begin
         base_in = BASE_HEX;
         if (step_char.digit < DIGIT_W'(BASE_HEX)) begin
            count_in = count_add(count_in, 2'd2);
            seen_in  = 1'b1;
            if (!ovf_in) begin
               m = mac(acc_in, base_in, step_char.digit, lim);
               if (m[VALUE_BITS]) ovf_in = 1'b1;
               else acc_in = m[VALUE_BITS-1:0];
            end
            phase_in = PH_DIGITS;
         end else begin
            emit = 1'b1;
         end
         done = 1'b1;
      end

      // Digit accumulation; any other character ends the number.
      if (!done && phase_in == PH_DIGITS) begin
         if (step_char.digit < DIGIT_W'(base_in)) begin
            seen_in = 1'b1;
            if (!ovf_in) begin
               m = mac(acc_in, base_in, step_char.digit, lim);
               if (m[VALUE_BITS]) ovf_in = 1'b1;
               else acc_in = m[VALUE_BITS-1:0];
            end
            count_in = count_add(count_in, 2'd1);
         end else begin
            emit = 1'b1;
         end
         done = 1'b1;
      end

      // Idle or unknown phase: the character is dropped.
      if (!done) begin
         phase_in = PH_IDLE;
      end

      // Build the result when the number ends.
      if (emit) begin
         phase_in = PH_IDLE;
         if (!seen_in) begin
            rsp_none_in = 1'b1;
         end else begin
            if (ovf_in) v = lim;
            else if (negative_in) v = VALUE_BITS'(0) - acc_in;
            else v = acc_in;
            rsp_value_in = VALUE_W'(v);
            rsp_range_in = ovf_in;
            rsp_count_in = count_in;
         end
      end
   end

   // Result register: loads a new result or empties when taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         negative_ff  <= 1'b0;
         base_ff      <= '0;
         acc_ff       <= '0;
         ovf_ff       <= 1'b0;
         count_ff     <= '0;
         seen_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            phase_ff    <= phase_in;
            negative_ff <= negative_in;
            base_ff     <= base_in;
            acc_ff      <= acc_in;
            ovf_ff      <= ovf_in;
            count_ff    <= count_in;
            seen_ff     <= seen_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (advance && emit) begin
         rsp_value_ff <= rsp_value_in;
         rsp_range_ff <= rsp_range_in;
         rsp_none_ff  <= rsp_none_in;
         rsp_count_ff <= rsp_count_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_count_ff, rsp_value_ff};
   always_comb begin
      rsp_tuser                = '0;
      rsp_tuser[FLAG_RANGE]    = rsp_range_ff;
      rsp_tuser[FLAG_NODIGITS] = rsp_none_ff;
   end

endmodule

// ----- hw/rtl/aip_checker.sv -----
// Port-level checks for the ASCII integer parser, bound to the top level.
// Depends on aip_pkg for widths and flag positions.
module aip_checker
   import aip_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata,
   input logic [RSP_TUSER_W-1:0] rsp_tuser
);

   // A stalled result word holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result word changed while stalled");

   // A string without digits reports zero value and zero count.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[FLAG_NODIGITS] |-> rsp_tdata == '0)
      else $error("no-digit result carries a value or count");

   // Overflow needs digits.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[FLAG_RANGE] && rsp_tuser[FLAG_NODIGITS]))
      else $error("range error flagged on a result without digits");

   // A fresh result follows a byte that passed through the input stage into the result register.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2))
      else $error("result appeared without a matching input byte");

endmodule

bind ascii_integer_parser aip_checker u_aip_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ----- tb/ascii_integer_parser_checker.sv -----
// Checker for the ASCII integer parser: watches the req, rsp and csr ports, predicts each
// result word from the accepted text bytes and compares it field by field.
// Depends on aip_pkg for widths, register indexes, radix values and flag positions.
module ascii_integer_parser_checker
   import aip_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // ch
   input  logic                   req_tuser,  // first
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,  // value[63:0], consumed[75:64], zero pad
   input  logic [RSP_TUSER_W-1:0] rsp_tuser,  // range_error, no_digits
   input  logic                   csr_we,
   input  logic [CSR_ADDR_W-1:0]  csr_addr,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     failures,
   output int                     pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_REPORTS = 50;

   // Characters that steer the parse.
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_PLUS    = "+";
   localparam logic [7:0] CH_MINUS   = "-";
   localparam logic [7:0] CH_ZERO    = "0";
   localparam logic [7:0] CH_NINE    = "9";
   localparam logic [7:0] CH_LOWER_A = "a";
   localparam logic [7:0] CH_LOWER_Z = "z";
   localparam logic [7:0] CH_UPPER_A = "A";
   localparam logic [7:0] CH_UPPER_Z = "Z";
   localparam logic [7:0] CH_LOWER_X = "x";
   localparam logic [7:0] CH_UPPER_X = "X";

   // Saturation points of the number.
   localparam logic [VALUE_W-1:0] VALUE_MASK   = {VALUE_W{1'b1}} >> (VALUE_W - VALUE_BITS);
   localparam logic [VALUE_W-1:0] SIGNED_MAX   = VALUE_MASK >> 1;
   localparam logic [VALUE_W-1:0] SIGNED_FLOOR = (VALUE_MASK >> 1) + 1'b1;

   typedef enum logic [2:0] {
      PARSE_IDLE,
      PARSE_BLANKS,
      PARSE_SIGN_DONE,
      PARSE_LEAD_ZERO,
      PARSE_X_MARK,
      PARSE_DIGITS
   } parse_phase_type;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               range_error;
      logic               no_digits;
      logic [COUNT_W-1:0] consumed;
   } parse_result_type;

   // Register copies and parse state of the prediction.
   logic [BASE_W-1:0]  base_reg;
   logic               signed_reg;
   parse_phase_type    phase;
   logic               negative;
   logic [BASE_W-1:0]  radix;
   logic [VALUE_W-1:0] magnitude;
   logic               overflowed;
   logic [COUNT_W-1:0] char_total;
   logic               any_digit;
   parse_result_type   expected_q [$];
   int                 results_checked;

   function automatic logic [DIGIT_W-1:0] digit_value(input logic [7:0] c);
      if (c >= CH_ZERO && c <= CH_NINE) return DIGIT_W'(c - CH_ZERO);
      if (c >= CH_LOWER_A && c <= CH_LOWER_Z) return DIGIT_W'(c - CH_LOWER_A + 8'd10);
      if (c >= CH_UPPER_A && c <= CH_UPPER_Z) return DIGIT_W'(c - CH_UPPER_A + 8'd10);
      return NOT_DIGIT;
   endfunction

   // Space and the control codes TAB, LF, VT, FF and CR.
   function automatic logic is_blank(input logic [7:0] c);
      return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
   endfunction

   function automatic logic [COUNT_W-1:0] sat_count(input logic [COUNT_W-1:0] c, input int n);
      int unsigned total;
      total = c + n;
      return (total > MAX_COUNT) ? MAX_COUNT : COUNT_W'(total);
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (failures < MAX_REPORTS) begin
         $display("mismatch in %s of result %0d: got %h, expected %h", what,
                  results_checked, got, want);
      end
      failures++;
   endtask

   // One more digit; once the magnitude limit is crossed the value is frozen.
   task automatic accumulate(input logic [DIGIT_W-1:0] d);
      logic [VALUE_W-1:0] limit;
      logic [VALUE_W-1:0] mult;
      any_digit = 1'b1;
      if (!overflowed) begin
         if (!signed_reg) limit = VALUE_MASK;
         else if (negative) limit = SIGNED_FLOOR;
         else limit = SIGNED_MAX;
         mult = (radix != BASE_AUTO) ? VALUE_W'(radix) : VALUE_W'(BASE_DEC);
         if (VALUE_W'(d) > limit || (limit - VALUE_W'(d)) / mult < magnitude) begin
            overflowed = 1'b1;
         end else begin
            magnitude = (magnitude * mult + VALUE_W'(d)) & VALUE_MASK;
         end
      end
   endtask

   // The byte that ends the number closes the string and forms the result word.
   task automatic conclude(output parse_result_type r);
      logic [VALUE_W-1:0] v;
      phase = PARSE_IDLE;
      r = '0;
      if (!any_digit) begin
         r.no_digits = 1'b1;
      end else begin
         if (overflowed) v = signed_reg ? (negative ? SIGNED_FLOOR : SIGNED_MAX) : VALUE_MASK;
         else v = negative ? (VALUE_W'(0) - magnitude) : magnitude;
         r.value       = v & VALUE_MASK;
         r.range_error = overflowed;
         r.consumed    = char_total;
      end
   endtask

   // Advance the parse by one text byte; a byte may pass through several phases.
   task automatic parse_byte(input logic [7:0] c, input logic first, output bit made,
                             output parse_result_type r);
      logic [DIGIT_W-1:0] d;
      bit again;
      made = 1'b0;
      r = '0;
      if (first) begin
         negative   = 1'b0;
         radix      = BASE_AUTO;
         magnitude  = '0;
         overflowed = 1'b0;
         char_total = '0;
         any_digit  = 1'b0;
         phase      = PARSE_BLANKS;
      end
      again = 1'b1;
      while (again) begin
         again = 1'b0;
         case (phase)
            PARSE_BLANKS: begin
               if (is_blank(c)) begin
                  char_total = sat_count(char_total, 1);
               end else begin
                  phase = PARSE_SIGN_DONE;
                  if (c == CH_PLUS || c == CH_MINUS) begin
                     negative   = (c == CH_MINUS);
                     char_total = sat_count(char_total, 1);
                  end else begin
                     again = 1'b1;
                  end
               end
            end
            PARSE_SIGN_DONE: begin
               // A leading zero may open a hex prefix in automatic and hex radix.
               if ((base_reg == BASE_AUTO || base_reg == BASE_HEX) && c == CH_ZERO) begin
                  radix      = base_reg;
                  magnitude  = '0;
                  any_digit  = 1'b1;
                  char_total = sat_count(char_total, 1);
                  phase      = PARSE_LEAD_ZERO;
               end else begin
                  radix = (base_reg == BASE_AUTO) ? BASE_DEC : base_reg;
                  phase = PARSE_DIGITS;
                  again = 1'b1;
               end
            end
            PARSE_LEAD_ZERO: begin
               if (c == CH_LOWER_X || c == CH_UPPER_X) begin
                  phase = PARSE_X_MARK;
               end else begin
                  radix = (radix == BASE_AUTO) ? BASE_OCT : BASE_HEX;
                  phase = PARSE_DIGITS;
                  again = 1'b1;
               end
            end
            PARSE_X_MARK: begin
               // The x counts only once a hex digit follows it.
               radix = BASE_HEX;
               d = digit_value(c);
               if (d < DIGIT_W'(BASE_HEX)) begin
                  char_total = sat_count(char_total, 2);
                  accumulate(d);
                  phase = PARSE_DIGITS;
               end else begin
                  conclude(r);
                  made = 1'b1;
               end
            end
            PARSE_DIGITS: begin
               d = digit_value(c);
               if (d < DIGIT_W'(radix)) begin
                  accumulate(d);
                  char_total = sat_count(char_total, 1);
               end else begin
                  conclude(r);
                  made = 1'b1;
               end
            end
            default: begin
               phase = PARSE_IDLE;
            end
         endcase
      end
   endtask

   // Follow register writes, predict on each text word, compare each result word.
   always @(posedge clock) begin : watch
      parse_result_type predicted;
      parse_result_type seen;
      bit made;
      if (reset) begin
         base_reg   = NUMBER_BASE_RST;
         signed_reg = 1'b1;
         phase      = PARSE_IDLE;
         negative   = 1'b0;
         radix      = BASE_AUTO;
         magnitude  = '0;
         overflowed = 1'b0;
         char_total = '0;
         any_digit  = 1'b0;
         expected_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_addr)
               REG_NUMBER_BASE: base_reg = csr_wdata[BASE_W-1:0];
               REG_SIGNED_MODE: signed_reg = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            parse_byte(req_tdata, req_tuser, made, predicted);
            if (made) expected_q.push_back(predicted);
         end
         if (rsp_tvalid && rsp_tready) begin
            seen.value       = rsp_tdata[VALUE_W-1:0];
            seen.consumed    = rsp_tdata[VALUE_W +: COUNT_W];
            seen.range_error = rsp_tuser[FLAG_RANGE];
            seen.no_digits   = rsp_tuser[FLAG_NODIGITS];
            if (expected_q.size() == 0) begin
               report_mismatch("word with none expected", seen.value, '0);
            end else begin
               predicted = expected_q.pop_front();
               if (seen.value != predicted.value)
                  report_mismatch("value", seen.value, predicted.value);
               if (seen.range_error != predicted.range_error)
                  report_mismatch("range_error", 64'(seen.range_error),
                                  64'(predicted.range_error));
               if (seen.no_digits != predicted.no_digits)
                  report_mismatch("no_digits", 64'(seen.no_digits),
                                  64'(predicted.no_digits));
               if (seen.consumed != predicted.consumed)
                  report_mismatch("consumed", 64'(seen.consumed), 64'(predicted.consumed));
               if (rsp_tdata[RSP_TDATA_W-1 -: RSP_PAD_W] != '0)
                  report_mismatch("pad bits", 64'(rsp_tdata[RSP_TDATA_W-1 -: RSP_PAD_W]),
                                  '0);
            end
            results_checked++;
         end
      end
      pending = expected_q.size();
   end

endmodule

// ----- tb/ascii_integer_parser_tb.sv -----
// Top of the ASCII integer parser testbench: clock, reset, text stimulus, register
// settings and receiver stalls. Depends on aip_pkg, ascii_integer_parser and the checker.
module ascii_integer_parser_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import aip_pkg::*;

   localparam int RANDOM_ITEMS  = 1550;
   localparam int SEGMENT_ITEMS = 130;
   localparam int LONG_ZEROS    = 4100;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 8;
   localparam int DRAIN_CYCLES  = 16;
   localparam int CYCLE_LIMIT   = 400000;

   localparam logic [7:0] CH_NUL     = 8'h00;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_PLUS    = "+";
   localparam logic [7:0] CH_MINUS   = "-";
   localparam logic [7:0] CH_ZERO    = "0";
   localparam logic [7:0] CH_LOWER_A = "a";
   localparam logic [7:0] CH_UPPER_A = "A";
   localparam logic [7:0] CH_LOWER_X = "x";
   localparam logic [7:0] CH_UPPER_X = "X";

   logic                   clock;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;  // ch
   logic                   req_tuser  = 1'b0;  // first
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;  // value[63:0], consumed[75:64], zero pad
   logic [RSP_TUSER_W-1:0] rsp_tuser;  // range_error, no_digits
   logic                   csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_addr   = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;
   int                     failures;
   int                     pending;

   int tx_idle_pct = 9;
   int rx_idle_pct = 70;
   int hold_left   = 0;
   int words_sent  = 0;
   int cycle_count = 0;

   ascii_integer_parser u_top (.*);

   ascii_integer_parser_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Give up on a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // Receiver: random stalls, or one long hold-off counted down here.
   initial begin
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   // Offer one text word from a falling edge and return at the falling edge after it is
   // taken; valid stays high so that a following word goes out back to back.
   task automatic send_word(input logic [7:0] ch, input logic first);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      req_tuser  <= first;
      do begin
         @(posedge clock);
      end while (!req_tready);
      @(negedge clock);
      words_sent++;
   endtask

   task automatic send_text(input string s, input bit start);
      for (int i = 0; i < s.len(); i++) send_word(s[i], start && i == 0);
   endtask

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // Close any open string, let the block drain, then load both registers.
   task automatic configure(input logic [BASE_W-1:0] base, input logic sgn);
      logic [4:0] junk;
      junk = 5'($urandom);
      send_word(CH_NUL, 1'b1);
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      write_reg(REG_NUMBER_BASE, CSR_DATA_W'(base));
      write_reg(REG_SIGNED_MODE, {junk, sgn});
   endtask

   function automatic logic [7:0] blank_char(input int k);
      return (k == 0) ? CH_SPACE : CH_TAB + 8'(k - 1);
   endfunction

   function automatic logic [7:0] digit_char(input int v);
      if (v < 10) return CH_ZERO + 8'(v);
      return ($urandom_range(1) ? CH_LOWER_A : CH_UPPER_A) + 8'(v - 10);
   endfunction

   // Mostly well-formed numbers with random content; the rest is noise.
   task automatic send_random_string(input logic [BASE_W-1:0] base);
      logic [7:0] text [$];
      int  span;
      int  radix;
      int  v;
      int  pick;
      bit  zero_lead;
      bit  hex_lead;
      bit  top_digits;
      if ($urandom_range(99) < 15) begin
         span = $urandom_range(1, 8);
         for (int i = 0; i < span; i++)
            send_word(8'($urandom), i == 0 || $urandom_range(3) == 0);
         return;
      end
      zero_lead = 1'b0;
      hex_lead  = 1'b0;
      if ($urandom_range(3) == 0) begin
         span = $urandom_range(1, 3);
         for (int i = 0; i < span; i++) text.push_back(blank_char($urandom_range(5)));
      end
      case ($urandom_range(2))
         0: text.push_back(CH_PLUS);
         1: text.push_back(CH_MINUS);
         default: ;
      endcase
      if ($urandom_range(3) == 0) begin
         text.push_back(CH_ZERO);
         zero_lead = 1'b1;
         if ($urandom_range(1)) begin
            text.push_back($urandom_range(1) ? CH_LOWER_X : CH_UPPER_X);
            hex_lead = 1'b1;
         end
      end
      if (base == BASE_AUTO) radix = hex_lead ? 16 : (zero_lead ? 8 : 10);
      else if (base > 36) radix = 36;
      else radix = base;
      // Digit count: mostly short, sometimes long enough to overflow.
      pick = $urandom_range(9);
      if (pick < 6) span = $urandom_range(0, 6);
      else if (pick < 9) span = $urandom_range(7, 16);
      else span = $urandom_range(17, 26);
      top_digits = ($urandom_range(4) == 0);
      for (int i = 0; i < span; i++) begin
         if (top_digits) v = radix - 1;
         else if ($urandom_range(19) == 0) v = $urandom_range(35);
         else v = $urandom_range(radix - 1);
         text.push_back(digit_char(v));
      end
      // Ending: NUL, any byte, a blank, or nothing so the next string abandons this one.
      pick = $urandom_range(9);
      if (pick < 4) text.push_back(CH_NUL);
      else if (pick < 7) text.push_back(8'($urandom));
      else if (pick < 9) text.push_back(blank_char($urandom_range(5)));
      for (int i = 0; i < text.size(); i++) send_word(text[i], i == 0);
      // Stray bytes outside a string are ignored.
      if ($urandom_range(5) == 0) send_word(8'($urandom), 1'b0);
   endtask

   initial begin : stimulus
      int random_start;
      int seg;
      int seg_end;
      logic [BASE_W-1:0] base;
      logic sgn;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: decimal, signed.
      for (int k = 0; k < 6; k++) send_word(blank_char(k), k == 0);
      send_text("-123;", 1'b0);
      send_text("9223372036854775807", 1'b1);
      send_word(CH_NUL, 1'b0);
      send_text("-9223372036854775808", 1'b1);
      send_word(CH_NUL, 1'b0);
      send_text("9223372036854775808", 1'b1);
      send_word(CH_NUL, 1'b0);
      send_text("-9223372036854775809", 1'b1);
      send_word(CH_NUL, 1'b0);
      send_text("+", 1'b1);
      send_word(CH_NUL, 1'b0);
      send_text("x", 1'b1);
      send_text("7", 1'b0);
      send_text("12", 1'b1);
      send_text("5", 1'b1);
      send_word(CH_NUL, 1'b0);
      send_word(8'hFF, 1'b1);

      // Automatic radix: prefixes, lone zero, octal.
      configure(BASE_AUTO, 1'b1);
      send_text("0x1F", 1'b1);
      send_word(CH_NUL, 1'b0);
      send_text("0755 ", 1'b1);
      send_text("0", 1'b1);
      send_word(CH_NUL, 1'b0);
      send_text("09", 1'b1);
      send_text("0xg", 1'b1);
      send_text("0X", 1'b1);
      send_word(CH_NUL, 1'b0);
      send_text("-0x10", 1'b1);
      send_word(CH_NUL, 1'b0);
      send_text("123", 1'b1);
      send_word(CH_NUL, 1'b0);

      configure(BASE_HEX, 1'b1);
      send_text("0x7fffffffffffffff", 1'b1);
      send_word(CH_NUL, 1'b0);
      send_text("-0x8000000000000000", 1'b1);
      send_word(CH_NUL, 1'b0);
      send_text("0x8000000000000000", 1'b1);
      send_word(CH_NUL, 1'b0);
      send_text("ffz", 1'b1);
      send_text("0xZ", 1'b1);

      // Unsigned: all ones, overflow, wrapped negation.
      configure(BASE_DEC, 1'b0);
      send_text("18446744073709551615", 1'b1);
      send_word(CH_NUL, 1'b0);
      send_text("18446744073709551616", 1'b1);
      send_word(CH_NUL, 1'b0);
      send_text("-1", 1'b1);
      send_word(CH_NUL, 1'b0);
      send_text("-18446744073709551615", 1'b1);
      send_word(CH_NUL, 1'b0);

      configure(6'd1, 1'b1);
      send_text("0001", 1'b1);
      send_word(CH_NUL, 1'b0);
      configure(6'd36, 1'b1);
      send_text("zZ!", 1'b1);
      configure(6'd63, 1'b0);
      send_text("zz9~", 1'b1);
      configure(6'd2, 1'b1);
      send_text("1012", 1'b1);

      // A string long enough to saturate the consumed count.
      configure(BASE_DEC, 1'b1);
      send_word(CH_SPACE, 1'b1);
      repeat (LONG_ZEROS) send_word(CH_ZERO, 1'b0);
      send_text("7", 1'b0);
      send_word(CH_NUL, 1'b0);

      // Random segments under three idling patterns, each with fresh settings.
      random_start = words_sent;
      for (int m = 0; m < 3; m++) begin
         case (m)
            0: begin
               tx_idle_pct = 9;
               rx_idle_pct = 70;
            end
            1: begin
               tx_idle_pct = 70;
               rx_idle_pct = 9;
            end
            default: begin
               tx_idle_pct = 0;
               rx_idle_pct = 0;
            end
         endcase
         seg = 0;
         while (words_sent - random_start < (m + 1) * RANDOM_ITEMS / 3) begin
            case ($urandom_range(7))
               0: base = BASE_AUTO;
               1: base = BASE_DEC;
               2: base = BASE_HEX;
               3: base = BASE_OCT;
               4: base = 6'd2;
               5: base = $urandom_range(1) ? 6'd1 : 6'd36;
               6: base = 6'($urandom_range(37, 63));
               default: base = 6'($urandom);
            endcase
            sgn = 1'($urandom);
            configure(base, sgn);
            // The receiver holds off while the sender keeps offering words.
            if (m == 2 && seg == 0) hold_left = HOLD_CYCLES;
            seg_end = words_sent + SEGMENT_ITEMS;
            while (words_sent < seg_end) send_random_string(base);
            seg++;
         end
      end

      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (failures == 0 && pending == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
hw/rtl/aip_pkg.sv
hw/rtl/aip_char_decode.sv
hw/rtl/aip_parse.sv
hw/rtl/ascii_integer_parser.sv
hw/rtl/aip_checker.sv
tb/ascii_integer_parser_checker.sv
tb/ascii_integer_parser_tb.sv
